/* design/assert_macros.svh */
// Assertion macros used by the checker file of the page table walker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off while in reset.
`define PTW_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");

// Next-cycle implication, sampled on the rising clock, off while in reset.
`define PTW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

/* design/ptw_pkg.sv */
// Shared types, constants and control structs of the page table walker.
`timescale 1ns / 1ps
`default_nettype none

package ptw_pkg;

    // Table store geometry
    localparam int TABLE_FRAMES      = 32;
    localparam int ENTRIES_PER_TABLE = 512;
    localparam int INDEX_W           = $clog2(ENTRIES_PER_TABLE);
    localparam int FRAME_W           = $clog2(TABLE_FRAMES);
    localparam int STORE_DEPTH       = TABLE_FRAMES * ENTRIES_PER_TABLE;
    localparam int STORE_AW          = FRAME_W + INDEX_W;

    // Field widths
    localparam int OP_W          = 2;
    localparam int VA_W          = 48;
    localparam int PA_W          = 52;
    localparam int FLAGS_W       = 12;
    localparam int ENTRY_W       = 64;
    localparam int STATUS_W      = 2;
    localparam int PAGE_W        = 36;
    localparam int ROOT_W        = 5;
    localparam int FRAME_FIELD_W = 40;

    // Bit positions
    localparam int L4_SHIFT      = 39;
    localparam int L3_SHIFT      = 30;
    localparam int L2_SHIFT      = 21;
    localparam int PAGE_SHIFT    = 12;
    localparam int ENTRY_SHIFT   = 3;
    localparam int PRESENT_BIT   = 0;
    localparam int HUGE_BIT      = 7;

    // Walk levels before the leaf
    localparam int LVL_W = 2;
    localparam logic [LVL_W-1:0] LVL_FIRST = 2'd0;
    localparam logic [LVL_W-1:0] LVL_MID   = 2'd1;
    localparam logic [LVL_W-1:0] LVL_LAST  = 2'd2;

    typedef enum logic [OP_W-1:0] {
        OP_MAP    = 2'd0,
        OP_UNMAP  = 2'd1,
        OP_RAW_WR = 2'd2,
        OP_RAW_RD = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE      = 2'd0,
        ST_WALK_FAIL = 2'd1,
        ST_OUTSIDE   = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        ADDR_CLEAR = 2'd0,
        ADDR_WALK  = 2'd1,
        ADDR_LEAF  = 2'd2,
        ADDR_RAW   = 2'd3
    } addr_sel_t;

    typedef enum logic [1:0] {
        WD_ZERO = 2'd0,
        WD_LEAF = 2'd1,
        WD_RAW  = 2'd2
    } wdata_sel_t;

    typedef enum logic [3:0] {
        FSM_CLEAR     = 4'd0,
        FSM_IDLE      = 4'd1,
        FSM_DECODE    = 4'd2,
        FSM_WALK_RD   = 4'd3,
        FSM_WALK_CHK  = 4'd4,
        FSM_LEAF_WR   = 4'd5,
        FSM_RAW_WR    = 4'd6,
        FSM_RAW_RD    = 4'd7,
        FSM_RES_DONE  = 4'd8,
        FSM_RES_FAIL  = 4'd9,
        FSM_RES_OUT   = 4'd10
    } fsm_state_t;

    // Controller to datapath
    typedef struct packed {
        logic       clear_step;
        logic       capture;
        logic       mem_rd;
        logic       mem_wr;
        addr_sel_t  addr_sel;
        wdata_sel_t wdata_sel;
        logic       frame_root;
        logic       frame_entry;
        logic       lvl_clear;
        logic       lvl_inc;
        logic       res_load;
        status_t    res_status;
    } ptw_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic clear_last;
        op_t  op;
        logic root_out;
        logic raw_out;
        logic entry_bad;
        logic entry_out;
        logic lvl_last;
        logic out_free;
    } ptw_stat_t;

endpackage

`default_nettype wire

/* design/page_table_map_unmap_walker.sv */
// Top level of the four-level page table map/unmap walker.
//
//   Channel   Direction  Handshake              Payload
//   s_        in         s_valid / s_ready      operation, addresses, flags, raw entry
//   m_        out        m_valid / m_ready      status, read value, invalidation
//   cfg_      in         cfg_wr_en              root table frame
//
// Map and unmap run from accept to result through decode, three read and
// check pairs on the single-port table store, the leaf write, the result load.
// Raw write and raw read go through decode, one store access and the result load;
// a failed check ends the walk early. After reset a clearing pass zeroes the
// store, one entry a cycle, with s_ready low; configuration writes are taken throughout.
// One result waits in the output register; the next request is accepted
// meanwhile and holds at its result step until m_ready takes the first.
`timescale 1ns / 1ps
`default_nettype none

module page_table_map_unmap_walker
    import ptw_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic [OP_W-1:0]      s_operation,
    input  wire logic [VA_W-1:0]      s_virtual_address,
    input  wire logic [PA_W-1:0]      s_physical_address,
    input  wire logic [FLAGS_W-1:0]   s_page_flags,
    input  wire logic [ENTRY_W-1:0]   s_raw_entry,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic [STATUS_W-1:0]       m_status,
    output logic [ENTRY_W-1:0]        m_read_value,
    output logic                      m_invalidate,
    output logic [PAGE_W-1:0]         m_invalidate_page,
    input  wire logic                 cfg_wr_en,
    input  wire logic [ROOT_W-1:0]    cfg_wr_data
);

    ptw_cmd_t  cmd;
    ptw_stat_t stat;

    // Sequencer
    ptw_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // Store and walk datapath
    ptw_datapath u_datapath (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_operation        (s_operation),
        .s_virtual_address  (s_virtual_address),
        .s_physical_address (s_physical_address),
        .s_page_flags       (s_page_flags),
        .s_raw_entry        (s_raw_entry),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_wr_data        (cfg_wr_data),
        .m_ready            (m_ready),
        .m_valid            (m_valid),
        .m_status           (m_status),
        .m_read_value       (m_read_value),
        .m_invalidate       (m_invalidate),
        .m_invalidate_page  (m_invalidate_page),
        .cmd                (cmd),
        .stat               (stat)
    );

endmodule

`default_nettype wire

/* design/ptw_ctrl.sv */
// Sequencing state machine of the page table walker.
`timescale 1ns / 1ps
`default_nettype none

module ptw_ctrl
    import ptw_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire ptw_stat_t stat,
    output ptw_cmd_t       cmd
);

    fsm_state_t state_reg;
    fsm_state_t state_next;

    // Hold the state; start with the clearing pass
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= FSM_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == FSM_IDLE);

    // Decide the next state and drive the datapath commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            FSM_CLEAR: begin
                cmd.mem_wr     = 1'b1;
                cmd.addr_sel   = ADDR_CLEAR;
                cmd.wdata_sel  = WD_ZERO;
                cmd.clear_step = 1'b1;
                if (stat.clear_last) begin
                    state_next = FSM_IDLE;
                end
            end
            FSM_IDLE: begin
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = FSM_DECODE;
                end
            end
            FSM_DECODE: begin
                if (stat.op == OP_MAP || stat.op == OP_UNMAP) begin
                    if (stat.root_out) begin
                        state_next = FSM_RES_OUT;
                    end else begin
                        cmd.frame_root = 1'b1;
                        cmd.lvl_clear  = 1'b1;
                        state_next     = FSM_WALK_RD;
                    end
                end else if (stat.raw_out) begin
                    state_next = FSM_RES_OUT;
                end else if (stat.op == OP_RAW_WR) begin
                    state_next = FSM_RAW_WR;
                end else begin
                    state_next = FSM_RAW_RD;
                end
            end
            FSM_WALK_RD: begin
                cmd.mem_rd   = 1'b1;
                cmd.addr_sel = ADDR_WALK;
                state_next   = FSM_WALK_CHK;
            end
            FSM_WALK_CHK: begin
                // Stop on a missing or huge entry, or a frame past the store
                if (stat.entry_bad) begin
                    state_next = FSM_RES_FAIL;
                end else if (stat.entry_out) begin
                    state_next = FSM_RES_OUT;
                end else begin
                    cmd.frame_entry = 1'b1;
                    if (stat.lvl_last) begin
                        state_next = FSM_LEAF_WR;
                    end else begin
                        cmd.lvl_inc = 1'b1;
                        state_next  = FSM_WALK_RD;
                    end
                end
            end
            FSM_LEAF_WR: begin
                cmd.mem_wr    = 1'b1;
                cmd.addr_sel  = ADDR_LEAF;
                cmd.wdata_sel = (stat.op == OP_MAP) ? WD_LEAF : WD_ZERO;
                state_next    = FSM_RES_DONE;
            end
            FSM_RAW_WR: begin
                cmd.mem_wr    = 1'b1;
                cmd.addr_sel  = ADDR_RAW;
                cmd.wdata_sel = WD_RAW;
                state_next    = FSM_RES_DONE;
            end
            FSM_RAW_RD: begin
                cmd.mem_rd   = 1'b1;
                cmd.addr_sel = ADDR_RAW;
                state_next   = FSM_RES_DONE;
            end
            FSM_RES_DONE: begin
                cmd.res_status = ST_DONE;
                if (stat.out_free) begin
                    cmd.res_load = 1'b1;
                    state_next   = FSM_IDLE;
                end
            end
            FSM_RES_FAIL: begin
                cmd.res_status = ST_WALK_FAIL;
                if (stat.out_free) begin
                    cmd.res_load = 1'b1;
                    state_next   = FSM_IDLE;
                end
            end
            FSM_RES_OUT: begin
                cmd.res_status = ST_OUTSIDE;
                if (stat.out_free) begin
                    cmd.res_load = 1'b1;
                    state_next   = FSM_IDLE;
                end
            end
            default: begin
                state_next = FSM_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* design/ptw_datapath.sv */
// Request registers, table store, walk address logic and result register.
`timescale 1ns / 1ps
`default_nettype none

module ptw_datapath
    import ptw_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic [OP_W-1:0]      s_operation,
    input  wire logic [VA_W-1:0]      s_virtual_address,
    input  wire logic [PA_W-1:0]      s_physical_address,
    input  wire logic [FLAGS_W-1:0]   s_page_flags,
    input  wire logic [ENTRY_W-1:0]   s_raw_entry,
    input  wire logic                 cfg_wr_en,
    input  wire logic [ROOT_W-1:0]    cfg_wr_data,
    input  wire logic                 m_ready,
    output logic                      m_valid,
    output logic [STATUS_W-1:0]       m_status,
    output logic [ENTRY_W-1:0]        m_read_value,
    output logic                      m_invalidate,
    output logic [PAGE_W-1:0]         m_invalidate_page,
    input  wire ptw_cmd_t             cmd,
    output ptw_stat_t                 stat
);

    localparam logic [FRAME_FIELD_W-1:0] FRAME_LIMIT = FRAME_FIELD_W'(TABLE_FRAMES);

    // Request fields
    op_t                  op_reg;
    logic [VA_W-1:0]      va_reg;
    logic [PA_W-1:0]      pa_reg;
    logic [FLAGS_W-1:0]   flags_reg;
    logic [ENTRY_W-1:0]   raw_reg;

    logic [ROOT_W-1:0]    root_reg;
    logic [FRAME_W-1:0]   frame_reg;
    logic [FRAME_W-1:0]   frame_next;
    logic [LVL_W-1:0]     lvl_reg;
    logic [LVL_W-1:0]     lvl_next;
    logic [STORE_AW-1:0]  clr_cnt_reg;
    logic [ENTRY_W-1:0]   rdata_reg;

    logic                 m_valid_reg;
    logic [STATUS_W-1:0]  m_status_reg;
    logic [ENTRY_W-1:0]   m_read_value_reg;
    logic                 m_invalidate_reg;
    logic [PAGE_W-1:0]    m_invalidate_page_reg;

    logic [ENTRY_W-1:0]   store_mem [STORE_DEPTH];

    logic [FRAME_FIELD_W-1:0] root_ext;
    logic [FRAME_FIELD_W-1:0] entry_frame;
    logic [FRAME_FIELD_W-1:0] raw_frame;
    logic [INDEX_W-1:0]       walk_idx;
    logic [STORE_AW-1:0]      mem_addr;
    logic [ENTRY_W-1:0]       mem_wdata;
    logic [ENTRY_W-1:0]       leaf_entry;
    logic                     res_ok;

    // Capture the request
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg    <= op_t'(s_operation);
            va_reg    <= s_virtual_address;
            pa_reg    <= s_physical_address;
            flags_reg <= s_page_flags;
            raw_reg   <= s_raw_entry;
        end
    end

    // Hold the root frame register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            root_reg <= '0;
        end else if (cfg_wr_en) begin
            root_reg <= cfg_wr_data;
        end
    end

    // Frame numbers, widened for the range checks
    assign root_ext    = FRAME_FIELD_W'(root_reg);
    assign entry_frame = rdata_reg[PAGE_SHIFT +: FRAME_FIELD_W];
    assign raw_frame   = pa_reg[PAGE_SHIFT +: FRAME_FIELD_W];

    // Advance the walk frame and level
    always_comb begin
        frame_next = frame_reg;
        if (cmd.frame_root) begin
            frame_next = root_ext[FRAME_W-1:0];
        end else if (cmd.frame_entry) begin
            frame_next = entry_frame[FRAME_W-1:0];
        end
        lvl_next = lvl_reg;
        if (cmd.lvl_clear) begin
            lvl_next = LVL_FIRST;
        end else if (cmd.lvl_inc) begin
            lvl_next = lvl_reg + LVL_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        frame_reg <= frame_next;
        lvl_reg   <= lvl_next;
    end

    // Step the clearing address
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
        end else if (cmd.clear_step) begin
            clr_cnt_reg <= clr_cnt_reg + STORE_AW'(1);
        end
    end

    // Pick the table index for the current level
    always_comb begin
        case (lvl_reg)
            LVL_FIRST: walk_idx = va_reg[L4_SHIFT +: INDEX_W];
            LVL_MID:   walk_idx = va_reg[L3_SHIFT +: INDEX_W];
            default:   walk_idx = va_reg[L2_SHIFT +: INDEX_W];
        endcase
    end

    // Select the store address
    always_comb begin
        case (cmd.addr_sel)
            ADDR_CLEAR: mem_addr = clr_cnt_reg;
            ADDR_WALK:  mem_addr = {frame_reg, walk_idx};
            ADDR_LEAF:  mem_addr = {frame_reg, va_reg[PAGE_SHIFT +: INDEX_W]};
            ADDR_RAW:   mem_addr = {pa_reg[PAGE_SHIFT +: FRAME_W],
                                    pa_reg[ENTRY_SHIFT +: INDEX_W]};
            default:    mem_addr = clr_cnt_reg;
        endcase
    end

    // Leaf entry: page frame, attribute bits, present
    assign leaf_entry = {{(ENTRY_W - PA_W){1'b0}}, pa_reg[PA_W-1:PAGE_SHIFT],
                         flags_reg[FLAGS_W-1:PRESENT_BIT+1], 1'b1};

    always_comb begin
        case (cmd.wdata_sel)
            WD_ZERO: mem_wdata = '0;
            WD_LEAF: mem_wdata = leaf_entry;
            WD_RAW:  mem_wdata = raw_reg;
            default: mem_wdata = '0;
        endcase
    end

    // Table store, one access per cycle, registered read
    always_ff @(posedge aclk) begin
        if (cmd.mem_wr) begin
            store_mem[mem_addr] <= mem_wdata;
        end
        if (cmd.mem_rd) begin
            rdata_reg <= store_mem[mem_addr];
        end
    end

    // Result register
    assign res_ok = (cmd.res_status == ST_DONE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.res_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.res_load) begin
            m_status_reg          <= cmd.res_status;
            m_read_value_reg      <= (res_ok && op_reg == OP_RAW_RD) ? rdata_reg : '0;
            m_invalidate_reg      <= res_ok && (op_reg == OP_MAP || op_reg == OP_UNMAP);
            m_invalidate_page_reg <= (res_ok && (op_reg == OP_MAP || op_reg == OP_UNMAP))
                                     ? va_reg[VA_W-1:PAGE_SHIFT] : '0;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_status          = m_status_reg;
    assign m_read_value      = m_read_value_reg;
    assign m_invalidate      = m_invalidate_reg;
    assign m_invalidate_page = m_invalidate_page_reg;

    // Report status to the controller
    always_comb begin
        stat.clear_last = (clr_cnt_reg == STORE_AW'(STORE_DEPTH - 1));
        stat.op         = op_reg;
        stat.root_out   = (root_ext >= FRAME_LIMIT);
        stat.raw_out    = (raw_frame >= FRAME_LIMIT);
        stat.entry_bad  = !rdata_reg[PRESENT_BIT] || rdata_reg[HUGE_BIT];
        stat.entry_out  = (entry_frame >= FRAME_LIMIT);
        stat.lvl_last   = (lvl_reg == LVL_LAST);
        stat.out_free   = !m_valid_reg || m_ready;
    end

endmodule

`default_nettype wire

/* design/ptw_checker.sv */
// Port-level checks of the page table walker, bound to its top level.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module ptw_checker
    import ptw_pkg::*;
(
    input wire logic                 aclk,
    input wire logic                 aresetn,
    input wire logic                 s_valid,
    input wire logic                 s_ready,
    input wire logic                 m_valid,
    input wire logic                 m_ready,
    input wire logic [STATUS_W-1:0]  m_status,
    input wire logic [ENTRY_W-1:0]   m_read_value,
    input wire logic                 m_invalidate,
    input wire logic [PAGE_W-1:0]    m_invalidate_page
);

    // A stalled result holds
    `PTW_ASSERT_NEXT(a_result_held, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_status) && $stable(m_read_value) && $stable(m_invalidate_page))

    // One request at a time: an accepted request drops ready
    `PTW_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready, !s_ready)

    // Invalidation only on success, and the page is zero without it
    `PTW_ASSERT_NOW(a_inv_on_done, aclk, aresetn, m_valid && m_invalidate, m_status == ST_DONE)
    `PTW_ASSERT_NOW(a_page_zero, aclk, aresetn, m_valid && !m_invalidate, m_invalidate_page == '0)

    // A read value comes only from a successful raw read
    `PTW_ASSERT_NOW(a_read_clean, aclk, aresetn, m_valid && m_read_value != '0, m_status == ST_DONE && !m_invalidate)

endmodule

bind page_table_map_unmap_walker ptw_checker u_ptw_checker (.*);

`default_nettype wire
